// ===== src/skin_weight_pack_normalize_macros.svh =====
// Assertion macros used by the skinning weight table top level.
`ifndef SKIN_WEIGHT_PACK_NORMALIZE_MACROS_SVH
`define SKIN_WEIGHT_PACK_NORMALIZE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SWPN_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SWPN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/swpn_pkg.sv =====
// Package: sizes, row layout and control structs of the skinning weight table.
`default_nettype none
package swpn_pkg;

  localparam int SLOTS     = 4;
  localparam int VERTICES  = 1024;
  localparam int JOINTS    = 256;
  localparam int REPORTED  = 4;
  localparam int SHOWN     = (SLOTS < REPORTED) ? SLOTS : REPORTED;
  localparam int ADDR_W    = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W     = 16 + $clog2(SLOTS);
  localparam int EPOCH_W   = 6;
  localparam int DIV_STEPS = 17;
  localparam int DCNT_W    = 5;

  typedef logic [15:0] weight_t;
  typedef logic [7:0]  joint_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]  tag;
    weight_t [SLOTS-1:0] w;
    joint_t  [SLOTS-1:0] j;
  } row_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    row_t              wr_row;
  } tbl_req_t;

  typedef struct packed {
    logic    start;
    weight_t dividend;
    sum_t    divisor;
  } div_req_t;

  typedef struct packed {
    logic    done;
    weight_t quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/swpn_if.sv =====
// Interfaces: command and response channels with valid/ready handshake.
`default_nettype none
interface swpn_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [9:0]         vertex_index;
  swpn_pkg::joint_t   joint_index;
  swpn_pkg::weight_t  weight;

  modport source (output valid, output opcode, output vertex_index, output joint_index,
                  output weight, input ready);
  modport sink   (input valid, input opcode, input vertex_index, input joint_index,
                  input weight, output ready);
endinterface

interface swpn_rsp_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [9:0]         out_vertex;
  swpn_pkg::weight_t  norm_weight0;
  swpn_pkg::weight_t  norm_weight1;
  swpn_pkg::weight_t  norm_weight2;
  swpn_pkg::weight_t  norm_weight3;
  swpn_pkg::joint_t   joint0;
  swpn_pkg::joint_t   joint1;
  swpn_pkg::joint_t   joint2;
  swpn_pkg::joint_t   joint3;

  modport source (output valid, output status, output out_vertex,
                  output norm_weight0, output norm_weight1, output norm_weight2,
                  output norm_weight3, output joint0, output joint1, output joint2,
                  output joint3, input ready);
  modport sink   (input valid, input status, input out_vertex,
                  input norm_weight0, input norm_weight1, input norm_weight2,
                  input norm_weight3, input joint0, input joint1, input joint2,
                  input joint3, output ready);
endinterface
`default_nettype wire

// ===== src/swpn_table.sv =====
// Slot table memory: one row per vertex, one write and one registered read per cycle.
`default_nettype none
module swpn_table (
  input  wire logic               clk,
  input  wire swpn_pkg::tbl_req_t req,
  output swpn_pkg::row_t          rd_row
);

  swpn_pkg::row_t mem [swpn_pkg::VERTICES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_row;
    end
    if (req.rd_en) begin
      rd_row <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/swpn_div.sv =====
// Radix-2 restoring divider: floor(w * 2^16 / sum), one quotient bit per cycle.
`default_nettype none
module swpn_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire swpn_pkg::div_req_t req,
  output swpn_pkg::div_rsp_t      rsp
);

  logic                         run;
  logic                         done;
  logic [swpn_pkg::DCNT_W-1:0]  cnt;
  logic [swpn_pkg::SUM_W:0]     rem;
  swpn_pkg::sum_t               dvs;
  logic [16:0]                  quo;

  logic                         qbit;
  logic [swpn_pkg::SUM_W:0]     diff;
  logic [swpn_pkg::SUM_W:0]     kept;
  logic [swpn_pkg::SUM_W:0]     rem_next;

  // Partial remainder stays below the divisor after each step, so the shift never overflows.
  always_comb begin
    qbit     = rem >= {1'b0, dvs};
    diff     = rem - {1'b0, dvs};
    kept     = qbit ? diff : rem;
    rem_next = {kept[swpn_pkg::SUM_W-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= swpn_pkg::DCNT_W'(swpn_pkg::DIV_STEPS);
        rem <= (swpn_pkg::SUM_W + 1)'(req.dividend);
        dvs <= req.divisor;
      end else if (run) begin
        rem <= rem_next;
        quo <= {quo[15:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == swpn_pkg::DCNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A lone full slot gives exactly one; saturate it.
  assign rsp.done     = done;
  assign rsp.quotient = quo[16] ? '1 : quo[15:0];

endmodule
`default_nettype wire

// ===== src/skin_weight_pack_normalize.sv =====
// Top level: per-vertex skinning influence table with normalized read-out.
//
// Usage:
//   cmd carries one word per command: opcode, vertex_index, joint_index, weight.
//   rsp returns exactly one word per command: status, out_vertex, the four
//   normalized weights and the four joint indices.
//   Add (1): writes weight and joint into the first slot of the vertex whose
//   weight is zero; status 1 when all slots are taken and the add is dropped.
//   Read (2): returns each slot weight times 2^16 over the slot sum, truncated
//   and saturated, with the joints; all weights zero when the sum is zero.
//   Clear (0): empties the table by bumping a generation tag; every 64th clear
//   also sweeps the memory.
// Flow: one command at a time; cmd.ready is high only while idle. A read
//   passes accept, table read, four divisions in turn on the shared divider
//   and output (no divisions if the sum is zero); an add passes accept,
//   table read and write, and output; a clear runs the sweep when due.
// Reset: rst (synchronous) starts a sweep that zeroes every row; cmd.ready
//   stays low until it ends.
// Stall: the response sits in an output register until rsp.ready; one more
//   command is taken meanwhile and its result waits until the slot frees.
`default_nettype none
`include "skin_weight_pack_normalize_macros.svh"
module skin_weight_pack_normalize (
  input wire logic clk,
  input wire logic rst,
  swpn_cmd_if.sink   cmd,
  swpn_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_DIV,
    S_DWAIT,
    S_DONE
  } state_t;

  localparam logic [swpn_pkg::EPOCH_W-1:0] EPOCH_LAST = '1;
  localparam logic [swpn_pkg::ADDR_W-1:0]  ADDR_LAST  =
    swpn_pkg::ADDR_W'(swpn_pkg::VERTICES - 1);
  localparam logic [1:0]                   K_LAST     = 2'(swpn_pkg::SHOWN - 1);

  state_t                          state;
  logic [swpn_pkg::ADDR_W-1:0]     clr_cnt;
  logic                            clr_reply;
  logic [swpn_pkg::EPOCH_W-1:0]    epoch;

  // Latched command fields
  swpn_pkg::op_t                   op_r;
  logic [9:0]                      vtx_r;
  swpn_pkg::joint_t                jnt_r;
  swpn_pkg::weight_t               wgt_r;

  // Working result and read-side operands
  swpn_pkg::row_t                  row_r;
  swpn_pkg::sum_t                  sum_r;
  logic [1:0]                      slot_k;
  logic                            res_status;
  swpn_pkg::weight_t               res_norm  [swpn_pkg::REPORTED];
  swpn_pkg::joint_t                res_joint [swpn_pkg::REPORTED];

  // Output register
  logic                            out_valid;
  logic                            out_status;
  logic [9:0]                      out_vtx;
  swpn_pkg::weight_t               out_norm  [swpn_pkg::REPORTED];
  swpn_pkg::joint_t                out_joint [swpn_pkg::REPORTED];

  swpn_pkg::tbl_req_t              tbl_req;
  swpn_pkg::row_t                  rd_row;
  swpn_pkg::div_req_t              div_req;
  swpn_pkg::div_rsp_t              div_rsp;

  logic                            accept;
  logic                            in_range;
  logic                            clr_last;
  swpn_pkg::row_t                  eff_row;
  swpn_pkg::sum_t                  row_sum;
  logic                            found;
  logic [swpn_pkg::SLOT_W-1:0]     free_idx;
  swpn_pkg::row_t                  add_row;
  logic                            joint_ok;

  swpn_table u_table (
    .clk    (clk),
    .req    (tbl_req),
    .rd_row (rd_row)
  );

  swpn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign in_range  = 32'(cmd.vertex_index) < swpn_pkg::VERTICES;
  assign joint_ok  = 32'(jnt_r) < swpn_pkg::JOINTS;
  assign clr_last  = (clr_cnt == ADDR_LAST);

  // Rows written under an older generation read as empty.
  always_comb begin
    eff_row = (rd_row.tag == epoch) ? rd_row : '0;
    row_sum = '0;
    for (int s = 0; s < swpn_pkg::SLOTS; s++) begin
      row_sum = row_sum + swpn_pkg::SUM_W'(eff_row.w[s]);
    end
  end

  // First empty slot; the joint is stored even for a zero weight.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int s = 0; s < swpn_pkg::SLOTS; s++) begin
      if (!found && (eff_row.w[s] == '0)) begin
        found    = 1'b1;
        free_idx = swpn_pkg::SLOT_W'(s);
      end
    end
    add_row           = eff_row;
    add_row.tag       = epoch;
    add_row.w[free_idx] = wgt_r;
    add_row.j[free_idx] = jnt_r;
  end

  always_comb begin
    tbl_req        = '0;
    tbl_req.wr_row = add_row;
    unique case (state)
      S_CLR: begin
        tbl_req.wr_en  = 1'b1;
        tbl_req.addr   = clr_cnt;
        tbl_req.wr_row = '0;
      end
      S_IDLE: begin
        tbl_req.rd_en = accept && in_range &&
                        ((swpn_pkg::op_t'(cmd.opcode) == swpn_pkg::OP_ADD) ||
                         (swpn_pkg::op_t'(cmd.opcode) == swpn_pkg::OP_READ));
        tbl_req.addr  = swpn_pkg::ADDR_W'(cmd.vertex_index);
      end
      S_RD: begin
        tbl_req.wr_en = (op_r == swpn_pkg::OP_ADD) && joint_ok && found;
        tbl_req.addr  = swpn_pkg::ADDR_W'(vtx_r);
      end
      default: begin
        tbl_req.addr = swpn_pkg::ADDR_W'(vtx_r);
      end
    endcase
  end

  assign div_req.start    = (state == S_DIV);
  assign div_req.dividend = row_r.w[swpn_pkg::SLOT_W'(slot_k)];
  assign div_req.divisor  = sum_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      epoch     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the held word once the receiver takes it; S_DONE reloads it itself.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_last ? '0 : clr_cnt + 1'b1;
          if (clr_last) begin
            epoch   <= '0;
            state   <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r       <= swpn_pkg::op_t'(cmd.opcode);
            vtx_r      <= cmd.vertex_index;
            jnt_r      <= cmd.joint_index;
            wgt_r      <= cmd.weight;
            res_status <= 1'b0;
            slot_k     <= '0;
            for (int i = 0; i < swpn_pkg::REPORTED; i++) begin
              res_norm[i]  <= '0;
              res_joint[i] <= '0;
            end
            unique case (swpn_pkg::op_t'(cmd.opcode))
              swpn_pkg::OP_CLEAR: begin
                if (epoch == EPOCH_LAST) begin
                  clr_reply <= 1'b1;
                  state     <= S_CLR;
                end else begin
                  epoch <= epoch + 1'b1;
                  state <= S_DONE;
                end
              end
              swpn_pkg::OP_ADD, swpn_pkg::OP_READ: begin
                state <= in_range ? S_RD : S_DONE;
              end
              swpn_pkg::OP_NONE: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          if (op_r == swpn_pkg::OP_ADD) begin
            res_status <= joint_ok && !found;
            state      <= S_DONE;
          end else begin
            row_r <= eff_row;
            sum_r <= row_sum;
            for (int i = 0; i < swpn_pkg::SHOWN; i++) begin
              res_joint[i] <= eff_row.j[swpn_pkg::SLOT_W'(i)];
            end
            // All weights stay zero when the sum is zero.
            state <= (row_sum == '0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            res_norm[slot_k] <= div_rsp.quotient;
            if (slot_k == K_LAST) begin
              state <= S_DONE;
            end else begin
              slot_k <= slot_k + 1'b1;
              state  <= S_DIV;
            end
          end
        end
        S_DONE: begin
          // Hold here while the previous word is still waiting.
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_vtx    <= vtx_r;
            for (int i = 0; i < swpn_pkg::REPORTED; i++) begin
              out_norm[i]  <= res_norm[i];
              out_joint[i] <= res_joint[i];
            end
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_vertex   = out_vtx;
  assign rsp.norm_weight0 = out_norm[0];
  assign rsp.norm_weight1 = out_norm[1];
  assign rsp.norm_weight2 = out_norm[2];
  assign rsp.norm_weight3 = out_norm[3];
  assign rsp.joint0       = out_joint[0];
  assign rsp.joint1       = out_joint[1];
  assign rsp.joint2       = out_joint[2];
  assign rsp.joint3       = out_joint[3];

  `SWPN_ASSERT_NEXT(a_busy_after_accept, accept, !cmd.ready, "command taken while busy")
  `SWPN_ASSERT_NOW(a_div_done_waited, div_rsp.done, state == S_DWAIT, "stray divider result")
  `SWPN_ASSERT_NOW(a_sweep_writes, state == S_CLR, tbl_req.wr_en && !tbl_req.rd_en, "sweep idle")
  `SWPN_ASSERT_NEXT(a_sweep_epoch, (state == S_CLR) && clr_last, epoch == '0, "epoch not reset")

endmodule
`default_nettype wire

// ===== tb/sv/skin_weight_pack_normalize_test.sv =====
// Self-checking test of the skinning weight table: directed and random command words.
`timescale 1ns / 1ps
module skin_weight_pack_normalize_test;
  import swpn_pkg::*;

  // Long receiver hold, quiet-cycle watchdog and the settle time at the end.
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 200;

  // One response word as the block should return it.
  typedef struct {
    logic       status;
    logic [9:0] vertex;
    weight_t    nw [REPORTED];
    joint_t     jt [REPORTED];
  } rsp_word_t;

  logic clk;
  logic rst;

  swpn_cmd_if cmd_if ();
  swpn_rsp_if rsp_if ();

  skin_weight_pack_normalize uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  // Shadow copy of the influence table, kept in step with accepted commands.
  weight_t shadow_weight [VERTICES][SLOTS];
  joint_t  shadow_joint  [VERTICES][SLOTS];

  // Expected response words, oldest first.
  rsp_word_t due_words [$];

  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_req;
  int   mismatches;
  int   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Empty every slot of the shadow table.
  function automatic void clear_shadow();
    for (int v = 0; v < VERTICES; v++) begin
      for (int s = 0; s < SLOTS; s++) begin
        shadow_weight[v][s] = '0;
        shadow_joint[v][s]  = '0;
      end
    end
  endfunction

  // Apply one command to the shadow table and return the word it must produce.
  function automatic rsp_word_t apply_command(op_t op, logic [9:0] v, joint_t j, weight_t w);
    rsp_word_t        r;
    bit               placed;
    longint unsigned  total;
    longint unsigned  quo;
    r.status = 1'b0;
    r.vertex = v;
    for (int k = 0; k < REPORTED; k++) begin
      r.nw[k] = '0;
      r.jt[k] = '0;
    end
    case (op)
      OP_CLEAR: clear_shadow();
      OP_ADD: begin
        if (v < VERTICES && j < JOINTS) begin
          // Take the first empty slot; a zero weight leaves it empty again.
          placed = 1'b0;
          for (int s = 0; s < SLOTS; s++) begin
            if (!placed && shadow_weight[v][s] == '0) begin
              shadow_weight[v][s] = w;
              shadow_joint[v][s]  = j;
              placed = 1'b1;
            end
          end
          r.status = !placed;
        end
      end
      OP_READ: begin
        if (v < VERTICES) begin
          total = 0;
          for (int s = 0; s < SLOTS; s++) total += shadow_weight[v][s];
          for (int s = 0; s < SLOTS && s < REPORTED; s++) begin
            quo = shadow_weight[v][s];
            if (total != 0) begin
              // Truncating Q0.16 quotient; a lone slot saturates at all ones.
              quo = (longint'(shadow_weight[v][s]) << 16) / total;
              if (quo > 64'hFFFF) quo = 64'hFFFF;
            end
            r.nw[s] = quo[15:0];
            r.jt[s] = shadow_joint[v][s];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly a small pool of vertices so that slots fill; sometimes any vertex.
  function automatic logic [9:0] pick_vertex();
    if ($urandom_range(0, 99) < 80) return 10'($urandom_range(0, 15));
    return 10'($urandom_range(0, VERTICES - 1));
  endfunction

  // Weights biased toward the extremes and tiny values that stress the divider.
  function automatic weight_t pick_weight();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 15));
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
  endtask

  // Offer one command word, idling first at random; hold valid high after the
  // handshake so the next word can follow without a gap.
  task automatic send_word(op_t op, logic [9:0] v, joint_t j, weight_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.opcode       <= op;
    cmd_if.vertex_index <= v;
    cmd_if.joint_index  <= j;
    cmd_if.weight       <= w;
    do @(posedge clk); while (!cmd_if.ready);
    due_words.push_back(apply_command(op, v, j, w));
  endtask

  // Drop valid and wait until every expected word has come back.
  task automatic wait_drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
  endtask

  // Extremes of every field, each opcode, a full vertex, a dropped add,
  // a zero-weight add, a lone saturating slot and reads of empty vertices.
  task automatic test_directed();
    send_word(OP_READ,  10'd0,    8'd0,   16'h0000);
    send_word(OP_ADD,   10'd0,    8'd255, 16'hFFFF);
    send_word(OP_READ,  10'd0,    8'd0,   16'h0000);
    send_word(OP_ADD,   10'd0,    8'd0,   16'h0001);
    send_word(OP_ADD,   10'd0,    8'd17,  16'h0000);
    send_word(OP_ADD,   10'd0,    8'd3,   16'h8000);
    send_word(OP_ADD,   10'd0,    8'd4,   16'h4000);
    send_word(OP_ADD,   10'd0,    8'd5,   16'h0007);
    send_word(OP_READ,  10'd0,    8'hFF,  16'hFFFF);
    send_word(OP_ADD,   10'd1023, 8'hAA,  16'h5555);
    send_word(OP_ADD,   10'd1023, 8'h55,  16'hAAAA);
    send_word(OP_READ,  10'd1023, 8'd0,   16'h0000);
    send_word(OP_NONE,  10'd512,  8'hFF,  16'hFFFF);
    send_word(OP_READ,  10'd512,  8'd0,   16'h0000);
    send_word(OP_CLEAR, 10'd1023, 8'hFF,  16'hFFFF);
    send_word(OP_READ,  10'd0,    8'd0,   16'h0000);
    send_word(OP_READ,  10'd1023, 8'd0,   16'h0000);
    wait_drain();
  endtask

  // Mostly add bursts on one vertex closed by a read; the rest clears and
  // single add, read or no-op commands with random content.
  task automatic test_random_mix(int count);
    int         sent;
    int         n;
    int         pick;
    logic [9:0] v;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        v = pick_vertex();
        n = $urandom_range(1, 6);
        repeat (n) send_word(OP_ADD, v, 8'($urandom), pick_weight());
        send_word(OP_READ, v, 8'($urandom), 16'($urandom));
        sent += n + 1;
      end else if (pick < 76) begin
        send_word(OP_CLEAR, 10'($urandom), 8'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_word(op_t'($urandom_range(1, 3)), pick_vertex(), 8'($urandom), pick_weight());
        sent++;
      end
    end
    wait_drain();
  endtask

  // Hold the receiver off while the sender keeps offering words, so the
  // block fills its output and stops taking commands.
  task automatic test_output_hold();
    logic [9:0] v;
    v = pick_vertex();
    hold_req = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) send_word(OP_ADD, v, 8'($urandom), pick_weight());
      else            send_word(OP_READ, v, 8'($urandom), 16'($urandom));
    end
    wait_drain();
  endtask

  // Enough clears back to back to pass the periodic memory sweep, with
  // occasional add and read pairs to see the table come back empty.
  task automatic test_clear_storm();
    logic [9:0] v;
    for (int k = 0; k < 66; k++) begin
      send_word(OP_CLEAR, 10'($urandom), 8'($urandom), 16'($urandom));
      if (k % 8 == 0) begin
        v = pick_vertex();
        send_word(OP_ADD, v, 8'($urandom), pick_weight());
        send_word(OP_READ, v, 8'($urandom), 16'($urandom));
      end
    end
    wait_drain();
  endtask

  // Receiver: random ready, or a long counted hold when asked for one.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_if.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted response word with the oldest expectation.
  always @(posedge clk) begin : check_rsp
    rsp_word_t got;
    rsp_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.status = rsp_if.status;
      got.vertex = rsp_if.out_vertex;
      got.nw     = '{rsp_if.norm_weight0, rsp_if.norm_weight1,
                     rsp_if.norm_weight2, rsp_if.norm_weight3};
      got.jt     = '{rsp_if.joint0, rsp_if.joint1, rsp_if.joint2, rsp_if.joint3};
      if (due_words.size() == 0) begin
        flag_mismatch("response word with nothing pending, vertex", 0, got.vertex);
      end else begin
        want = due_words.pop_front();
        if (got.status !== want.status) flag_mismatch("status", want.status, got.status);
        if (got.vertex !== want.vertex) flag_mismatch("out_vertex", want.vertex, got.vertex);
        for (int k = 0; k < REPORTED; k++) begin
          if (got.nw[k] !== want.nw[k])
            flag_mismatch($sformatf("norm_weight%0d", k), want.nw[k], got.nw[k]);
          if (got.jt[k] !== want.jt[k])
            flag_mismatch($sformatf("joint%0d", k), want.jt[k], got.jt[k]);
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mismatches    = 0;
    quiet_cycles  = 0;
    hold_req      = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst                 <= 1'b1;
    cmd_if.valid        <= 1'b0;
    cmd_if.opcode       <= OP_NONE;
    cmd_if.vertex_index <= '0;
    cmd_if.joint_index  <= '0;
    cmd_if.weight       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase one: sender idles often, receiver idles more.
    send_idle_pct = 37;
    recv_idle_pct = 63;
    test_directed();
    test_random_mix(330);
    test_output_hold();

    // Phase two: the other way round.
    send_idle_pct = 63;
    recv_idle_pct = 37;
    test_random_mix(330);
    test_output_hold();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(330);
    test_clear_storm();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
